// File: hw/rtl/ifst_pkg.sv
package ifst_pkg;

  localparam int FLOW_ENTRIES = 64;
  localparam int SLOT_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
  localparam int OUT_SLOT_W = 6;

  localparam int BYTE_W = 48;
  localparam int PKT_W = 32;
  localparam int LEN_W = 16;

  localparam logic [LEN_W-1:0] MIN_CAPTURE = 16'd14;
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;
  localparam logic [31:0] LOCAL_RESET = 32'd2130706433;

  localparam logic [1:0] ST_IGNORED = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_NEW = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // flags bit 0 is transmit, bit 1 is ipv6
  typedef struct packed {
    logic [1:0]  flags;
    logic [63:0] dest_low;
    logic [63:0] dest_high;
    logic [63:0] source_low;
    logic [63:0] source_high;
  } key_t;

  typedef struct packed {
    logic [LEN_W-1:0]  peak;
    logic [PKT_W-1:0]  packets;
    logic [BYTE_W-1:0] bytes;
  } stats_t;

endpackage

// File: hw/rtl/ip_flow_statistics_table.sv
// steps: an ignored frame goes from acceptance straight to the result state; an ip frame
// passes a global update, a scan over the key memory read port (none when the table is
// empty), an entry update (none when the table is full) and the result state
// handshake: one frame at a time; in_tready is high only while idle, so no new frame is taken
// before the last result is registered, nor while a held result blocks the output register
// reset: synchronous active-low rst_n empties the table, clears totals, local_ipv4 = 127.0.0.1
module ip_flow_statistics_table (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [31:0]   cfg_wr_data,
  input  logic          in_tvalid,
  output logic          in_tready,
  // captured_length, frame_length, ether_type, source_high, source_low,
  // dest_high, dest_low
  input  logic [303:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // status, flow_slot, is_transmit, flow_byte_total, flow_packet_total,
  // flow_peak_length, receive_total, transmit_total, global_peak_length, zero fill
  output logic [223:0]  out_tdata
);

  import ifst_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GLOB = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FLOW_ENTRIES);

  logic [2:0]        state_r, state_nxt;
  logic [31:0]       local_r, local_nxt;
  key_t              key_r, key_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              dir_tx_r, dir_tx_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  stats_t            res_stats_r, res_stats_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic [SLOT_W-1:0] chk_r, chk_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [BYTE_W-1:0] rx_sum_r, rx_sum_nxt;
  logic [BYTE_W-1:0] tx_sum_r, tx_sum_nxt;
  logic [LEN_W-1:0]  peak_r, peak_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [223:0]      out_data_r, out_data_nxt;

  logic [LEN_W-1:0]  in_caplen, in_len, in_etype;
  logic              in_v6, in_tx, in_ignore, in_acc;
  key_t              in_key;

  key_t              key_rdata;
  stats_t            stat_rdata, stat_wdata;
  logic              key_match, key_wr, stat_wr, rd_issue;
  logic [BYTE_W-1:0] add_acc, add_sum;
  logic [PKT_W-1:0]  pkt_inc;
  logic              match_hit, scan_last;

  assign in_caplen = in_tdata[15:0];
  assign in_len    = in_tdata[31:16];
  assign in_etype  = in_tdata[47:32];
  assign in_v6     = (in_etype == ETH_IPV6);
  assign in_ignore = (in_caplen < MIN_CAPTURE) ||
                     ((in_etype != ETH_IPV4) && (in_etype != ETH_IPV6));

  // ipv4 addresses keep only their low 32 bits
  always_comb begin
    in_key.source_high = in_v6 ? in_tdata[111:48] : 64'd0;
    in_key.source_low  = in_v6 ? in_tdata[175:112] : {32'd0, in_tdata[143:112]};
    in_key.dest_high   = in_v6 ? in_tdata[239:176] : 64'd0;
    in_key.dest_low    = in_v6 ? in_tdata[303:240] : {32'd0, in_tdata[271:240]};
    in_tx              = in_v6 || (in_key.dest_low != {32'd0, local_r});
    in_key.flags       = {in_v6, in_tx};
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  ifst_key_cmp u_cmp (
    .key_a (key_r),
    .key_b (key_rdata),
    .match (key_match)
  );

  assign add_acc = (state_r == S_GLOB) ? (dir_tx_r ? tx_sum_r : rx_sum_r)
                                       : stat_rdata.bytes;

  ifst_sat_add u_add (
    .acc (add_acc),
    .len (len_r),
    .sum (add_sum)
  );

  assign pkt_inc = (stat_rdata.packets == {PKT_W{1'b1}}) ? stat_rdata.packets
                                                         : stat_rdata.packets + 1'b1;

  assign match_hit = chk_v_r && key_match;
  assign scan_last = chk_v_r && (CNT_W'(chk_r) == (used_r - 1'b1));
  assign rd_issue  = (state_r == S_SCAN) && !match_hit && (iss_r < used_r);

  always_comb begin
    if (res_status_r == ST_FOUND) begin
      stat_wdata.bytes   = add_sum;
      stat_wdata.packets = pkt_inc;
      stat_wdata.peak    = (len_r > stat_rdata.peak) ? len_r : stat_rdata.peak;
    end else begin
      stat_wdata.bytes   = {{(BYTE_W - LEN_W){1'b0}}, len_r};
      stat_wdata.packets = PKT_W'(1);
      stat_wdata.peak    = len_r;
    end
  end

  assign stat_wr = (state_r == S_UPD);
  assign key_wr  = (state_r == S_UPD) && (res_status_r == ST_NEW);

  ifst_ram #(
    .WIDTH ($bits(key_t)),
    .DEPTH (FLOW_ENTRIES)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr),
    .wr_addr (slot_r),
    .wr_data (key_r),
    .rd_en   (rd_issue),
    .rd_addr (iss_r[SLOT_W-1:0]),
    .rd_data (key_rdata)
  );

  ifst_ram #(
    .WIDTH ($bits(stats_t)),
    .DEPTH (FLOW_ENTRIES)
  ) u_stat_ram (
    .clk     (clk),
    .wr_en   (stat_wr),
    .wr_addr (slot_r),
    .wr_data (stat_wdata),
    .rd_en   (rd_issue),
    .rd_addr (iss_r[SLOT_W-1:0]),
    .rd_data (stat_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    local_nxt      = cfg_wr_en ? cfg_wr_data : local_r;
    key_nxt        = key_r;
    len_nxt        = len_r;
    dir_tx_nxt     = dir_tx_r;
    res_status_nxt = res_status_r;
    slot_nxt       = slot_r;
    res_stats_nxt  = res_stats_r;
    iss_nxt        = iss_r;
    chk_nxt        = chk_r;
    chk_v_nxt      = chk_v_r;
    used_nxt       = used_r;
    rx_sum_nxt     = rx_sum_r;
    tx_sum_nxt     = tx_sum_r;
    peak_nxt       = peak_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_nxt       = in_key;
          len_nxt       = in_len;
          dir_tx_nxt    = in_ignore ? 1'b0 : in_tx;
          slot_nxt      = '0;
          res_stats_nxt = '0;
          if (in_ignore) begin
            res_status_nxt = ST_IGNORED;
            state_nxt      = S_FIN;
          end else begin
            state_nxt = S_GLOB;
          end
        end
      end
      S_GLOB: begin
        if (dir_tx_r) begin
          tx_sum_nxt = add_sum;
        end else begin
          rx_sum_nxt = add_sum;
        end
        if (len_r > peak_r) begin
          peak_nxt = len_r;
        end
        iss_nxt   = '0;
        chk_v_nxt = 1'b0;
        if (used_r == '0) begin
          res_status_nxt = ST_NEW;
          slot_nxt       = '0;
          state_nxt      = S_UPD;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // read of entry iss_r overlaps the compare of entry chk_r
        chk_v_nxt = rd_issue;
        chk_nxt   = iss_r[SLOT_W-1:0];
        if (rd_issue) begin
          iss_nxt = iss_r + 1'b1;
        end
        if (match_hit) begin
          res_status_nxt = ST_FOUND;
          slot_nxt       = chk_r;
          state_nxt      = S_UPD;
        end else if (scan_last) begin
          if (used_r == FULL_CNT) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_FIN;
          end else begin
            res_status_nxt = ST_NEW;
            slot_nxt       = used_r[SLOT_W-1:0];
            state_nxt      = S_UPD;
          end
        end
      end
      S_UPD: begin
        res_stats_nxt = stat_wdata;
        if (res_status_r == ST_NEW) begin
          used_nxt = used_r + 1'b1;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = {7'd0, peak_r, tx_sum_r, rx_sum_r, res_stats_r.peak,
                            res_stats_r.packets, res_stats_r.bytes, dir_tx_r,
                            OUT_SLOT_W'(slot_r), res_status_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      local_r      <= LOCAL_RESET;
      used_r       <= '0;
      rx_sum_r     <= '0;
      tx_sum_r     <= '0;
      peak_r       <= '0;
      out_tvalid_r <= 1'b0;
      chk_v_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      local_r      <= local_nxt;
      used_r       <= used_nxt;
      rx_sum_r     <= rx_sum_nxt;
      tx_sum_r     <= tx_sum_nxt;
      peak_r       <= peak_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      chk_v_r      <= chk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    len_r        <= len_nxt;
    dir_tx_r     <= dir_tx_nxt;
    res_status_r <= res_status_nxt;
    slot_r       <= slot_nxt;
    res_stats_r  <= res_stats_nxt;
    iss_r        <= iss_nxt;
    chk_r        <= chk_nxt;
    out_data_r   <= out_data_nxt;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= FULL_CNT)
    else $error("entry count beyond table size");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[1:0] == ST_FULL)) |-> (used_r == FULL_CNT))
    else $error("table full reported with free entries");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready again right after accepting a beat");

  a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && res_status_r == ST_NEW) |=> (used_r == $past(used_r) + 1'b1))
    else $error("new entry did not advance entry count");

endmodule

// File: hw/rtl/ifst_ram.sv
module ifst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/ifst_key_cmp.sv
module ifst_key_cmp (
  input  ifst_pkg::key_t key_a,
  input  ifst_pkg::key_t key_b,
  output logic           match
);

  import ifst_pkg::*;

  // halves compared separately, then combined
  logic src_eq;
  logic dst_eq;

  assign src_eq = (key_a.source_high == key_b.source_high) &&
                  (key_a.source_low == key_b.source_low);
  assign dst_eq = (key_a.dest_high == key_b.dest_high) &&
                  (key_a.dest_low == key_b.dest_low);
  assign match = src_eq && dst_eq && (key_a.flags == key_b.flags);

endmodule

// File: hw/rtl/ifst_sat_add.sv
module ifst_sat_add (
  input  logic [ifst_pkg::BYTE_W-1:0] acc,
  input  logic [ifst_pkg::LEN_W-1:0]  len,
  output logic [ifst_pkg::BYTE_W-1:0] sum
);

  import ifst_pkg::*;

  logic [BYTE_W:0] raw;

  assign raw = {1'b0, acc} + {{(BYTE_W + 1 - LEN_W){1'b0}}, len};
  assign sum = raw[BYTE_W] ? {BYTE_W{1'b1}} : raw[BYTE_W-1:0];

endmodule

// File: tb/sv/ip_flow_statistics_table_tb.sv
module ip_flow_statistics_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ifst_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASE_FRAMES = 280;
  localparam int POOL_SIZE = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 80;

  // packed so that the last field lands in the lowest bits of in_tdata
  typedef struct packed {
    logic [63:0] dest_low;
    logic [63:0] dest_high;
    logic [63:0] source_low;
    logic [63:0] source_high;
    logic [15:0] ether_type;
    logic [15:0] frame_length;
    logic [15:0] captured_length;
  } frame_t;

  typedef struct packed {
    logic [6:0]  fill;
    logic [15:0] global_peak_length;
    logic [47:0] transmit_total;
    logic [47:0] receive_total;
    logic [15:0] flow_peak_length;
    logic [31:0] flow_packet_total;
    logic [47:0] flow_byte_total;
    logic        is_transmit;
    logic [5:0]  flow_slot;
    logic [1:0]  status;
  } flow_result_t;

  class flow_table_model;
    key_t flow_keys[FLOW_ENTRIES];
    stats_t flow_stats[FLOW_ENTRIES];
    int used;
    logic [47:0] rx_sum;
    logic [47:0] tx_sum;
    logic [15:0] peak;
    logic [31:0] host_addr;
    flow_result_t pending[$];
    int errors;

    function new();
      used = 0;
      rx_sum = '0;
      tx_sum = '0;
      peak = '0;
      host_addr = LOCAL_RESET;
      errors = 0;
    endfunction

    function logic [47:0] add_bytes(logic [47:0] a, logic [15:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {33'd0, b};
      return s[48] ? '1 : s[47:0];
    endfunction

    function void note_frame(frame_t f);
      flow_result_t r;
      key_t k;
      logic v6;
      logic tx;
      int hit;
      int i;
      r = '0;
      if (f.captured_length >= MIN_CAPTURE &&
          (f.ether_type == ETH_IPV4 || f.ether_type == ETH_IPV6)) begin
        v6 = (f.ether_type == ETH_IPV6);
        // ipv4 keys keep only the low 32 bits of each address
        k.source_high = v6 ? f.source_high : 64'd0;
        k.source_low = v6 ? f.source_low : {32'd0, f.source_low[31:0]};
        k.dest_high = v6 ? f.dest_high : 64'd0;
        k.dest_low = v6 ? f.dest_low : {32'd0, f.dest_low[31:0]};
        tx = v6 || (k.dest_low != {32'd0, host_addr});
        k.flags = {v6, tx};
        if (tx) begin
          tx_sum = add_bytes(tx_sum, f.frame_length);
        end else begin
          rx_sum = add_bytes(rx_sum, f.frame_length);
        end
        if (f.frame_length > peak) begin
          peak = f.frame_length;
        end
        hit = -1;
        for (i = 0; i < used; i++) begin
          if (hit < 0 && flow_keys[i] == k) begin
            hit = i;
          end
        end
        r.is_transmit = tx;
        if (hit >= 0) begin
          flow_stats[hit].bytes = add_bytes(flow_stats[hit].bytes, f.frame_length);
          if (flow_stats[hit].packets != '1) begin
            flow_stats[hit].packets = flow_stats[hit].packets + 1;
          end
          if (f.frame_length > flow_stats[hit].peak) begin
            flow_stats[hit].peak = f.frame_length;
          end
          r.status = ST_FOUND;
        end else if (used < FLOW_ENTRIES) begin
          hit = used;
          flow_keys[hit] = k;
          flow_stats[hit].bytes = {32'd0, f.frame_length};
          flow_stats[hit].packets = 32'd1;
          flow_stats[hit].peak = f.frame_length;
          used++;
          r.status = ST_NEW;
        end else begin
          r.status = ST_FULL;
        end
        if (hit >= 0) begin
          r.flow_slot = hit[5:0];
          r.flow_byte_total = flow_stats[hit].bytes;
          r.flow_packet_total = flow_stats[hit].packets;
          r.flow_peak_length = flow_stats[hit].peak;
        end
      end else begin
        r.status = ST_IGNORED;
      end
      r.receive_total = rx_sum;
      r.transmit_total = tx_sum;
      r.global_peak_length = peak;
      pending.push_back(r);
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
      end
    endfunction

    function void check_result(logic [223:0] data);
      flow_result_t got;
      flow_result_t want;
      got = data;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %0h", $time, data);
      end else begin
        want = pending.pop_front();
        compare("status", want.status, got.status);
        compare("flow_slot", want.flow_slot, got.flow_slot);
        compare("is_transmit", want.is_transmit, got.is_transmit);
        compare("flow_byte_total", want.flow_byte_total, got.flow_byte_total);
        compare("flow_packet_total", want.flow_packet_total, got.flow_packet_total);
        compare("flow_peak_length", want.flow_peak_length, got.flow_peak_length);
        compare("receive_total", want.receive_total, got.receive_total);
        compare("transmit_total", want.transmit_total, got.transmit_total);
        compare("global_peak_length", want.global_peak_length, got.global_peak_length);
        compare("zero fill", want.fill, got.fill);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic in_tvalid;
  logic in_tready;
  logic [303:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [223:0] out_tdata;

  flow_table_model flow_model = new();
  frame_t flow_pool[POOL_SIZE];
  logic [31:0] local_setting = LOCAL_RESET;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  bit hold_req = 1'b0;
  int cycles = 0;

  ip_flow_statistics_table dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = stalls_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      flow_model.check_result(out_tdata);
    end
  end

  function automatic frame_t make_frame(logic [15:0] cap, logic [15:0] len, logic [15:0] etype,
                                        logic [63:0] sh, logic [63:0] sl, logic [63:0] dh,
                                        logic [63:0] dl);
    frame_t f;
    f.captured_length = cap;
    f.frame_length = len;
    f.ether_type = etype;
    f.source_high = sh;
    f.source_low = sl;
    f.dest_high = dh;
    f.dest_low = dl;
    return f;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit is_counted(frame_t f);
    return f.captured_length >= MIN_CAPTURE &&
           (f.ether_type == ETH_IPV4 || f.ether_type == ETH_IPV6);
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      f = flow_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (f.ether_type == ETH_IPV4) begin
        // junk above the ipv4 address must not change the key
        f.source_high = rand64();
        f.dest_high = rand64();
        f.source_low[63:32] = $urandom;
        f.dest_low[63:32] = $urandom;
        if ($urandom_range(0, 2) == 0) begin
          f.dest_low[31:0] = local_setting;
        end
      end
    end else if (pick < 80) begin
      f = make_frame(0, 0, $urandom_range(0, 1) ? ETH_IPV6 : ETH_IPV4,
                     rand64(), rand64(), rand64(), rand64());
    end else if (pick < 90) begin
      f = make_frame(16'($urandom_range(0, 13)), 0,
                     $urandom_range(0, 1) ? ETH_IPV6 : ETH_IPV4,
                     rand64(), rand64(), rand64(), rand64());
    end else begin
      f = make_frame(16'($urandom), 0, 16'($urandom), rand64(), rand64(), rand64(), rand64());
    end
    if (pick < 80) begin
      f.captured_length = $urandom_range(0, 9) == 0 ? 16'd14 : 16'($urandom_range(14, 65535));
    end
    case ($urandom_range(0, 9))
      0: f.frame_length = 16'd0;
      1: f.frame_length = 16'hFFFF;
      2, 3: f.frame_length = 16'($urandom_range(14, 1518));
      default: f.frame_length = 16'($urandom);
    endcase
    return f;
  endfunction

  task automatic send_frame(frame_t f);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = f;
    in_tvalid = 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    flow_model.note_frame(f);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (flow_model.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_local(logic [31:0] value);
    wait_drained();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    flow_model.host_addr = value;
    local_setting = value;
  endtask

  task automatic run_directed();
    send_frame(make_frame(0, 100, ETH_IPV4, 0, 0, 0, 64'h7F00_0001));
    send_frame(make_frame(13, 100, ETH_IPV4, 0, 0, 0, 64'h7F00_0001));
    // receive flow, shortest capture, zero length
    send_frame(make_frame(14, 0, ETH_IPV4, 0, 64'h0A00_0001, 0, 64'h7F00_0001));
    send_frame(make_frame(16'hFFFF, 16'hFFFF, ETH_IPV4, 0, 64'h0A00_0001, 0, 64'h7F00_0001));
    send_frame(make_frame(200, 1000, ETH_IPV4, '1, 64'hFFFF_FFFF_0A00_0001, '1,
                          64'hFFFF_FFFF_7F00_0001));
    send_frame(make_frame(1500, 1500, ETH_IPV4, 0, 64'hC0A8_0001, 0, 64'h0808_0808));
    send_frame(make_frame(64, 64, ETH_IPV6, 0, 0, 0, 0));
    send_frame(make_frame(16'hFFFF, 16'hFFFF, ETH_IPV6, '1, '1, '1, '1));
    // ipv6 never counts as receive, even with the local address in the low bits
    send_frame(make_frame(60, 60, ETH_IPV6, 0, 64'h0A00_0001, 0, 64'h7F00_0001));
    send_frame(make_frame(60, 60, ETH_IPV4, 0, 0, 0, 0));
    send_frame(make_frame(60, 70, ETH_IPV4, 0, 64'h7F00_0001, 0, 64'h0A00_0001));
    send_frame(make_frame(16'hFFFF, 80, 16'h0801, 0, 0, 0, 64'h7F00_0001));
    send_frame(make_frame(16'hFFFF, 80, 16'h86DC, '1, '1, '1, '1));
    send_frame(make_frame(16'hFFFF, 80, 16'hFFFF, '1, '1, '1, '1));
    send_frame(make_frame(16'hFFFF, 80, 16'h0000, 0, 0, 0, 0));
    send_frame(make_frame(14, 20, ETH_IPV6, '1, '1, '1, '1));
    send_frame(make_frame(100, 0, ETH_IPV4, 64'h1234, 64'h5555_0000_C0A8_0001, 64'h9,
                          64'h0808_0808));
    wait_drained();
  endtask

  task automatic run_phase(logic [31:0] local_value, int phase);
    frame_t f;
    int counted;
    bit mid_done;
    write_local(local_value);
    counted = 0;
    mid_done = 1'b0;
    while (counted < PHASE_FRAMES) begin
      if (counted % 64 == 0) begin
        gaps_on = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
      end
      if (!mid_done && counted == PHASE_FRAMES / 2) begin
        mid_done = 1'b1;
        if (phase == 0) begin
          hold_req = 1'b1;
        end else if (phase == 1) begin
          wait_drained();
        end
      end
      f = random_frame();
      send_frame(f);
      if (is_counted(f)) begin
        counted++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      flow_pool[i] = make_frame(0, 0, (i % 3 == 0) ? ETH_IPV6 : ETH_IPV4,
                                rand64(), rand64(), rand64(), rand64());
    end
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    run_phase(32'h0000_0000, 0);
    run_phase(32'hFFFF_FFFF, 1);
    run_phase($urandom, 2);
    run_phase(LOCAL_RESET, 3);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (flow_model.errors == 0 && flow_model.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: ip_flow_statistics_table.f
hw/rtl/ifst_pkg.sv
hw/rtl/ifst_ram.sv
hw/rtl/ifst_key_cmp.sv
hw/rtl/ifst_sat_add.sv
hw/rtl/ip_flow_statistics_table.sv
tb/sv/ip_flow_statistics_table_tb.sv
